// ----- rtl/sac_pkg.sv -----
// Shared types, constants and helpers for the set-associative LRU cache model.
package sac_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 64;

    localparam logic [1:0] FUNC_INSTR  = 2'd0;
    localparam logic [1:0] FUNC_MODIFY = 2'd3;

    localparam logic [1:0] OUT_NONE  = 2'd0;
    localparam logic [1:0] OUT_HIT   = 2'd1;
    localparam logic [1:0] OUT_MISS  = 2'd2;
    localparam logic [1:0] OUT_EVICT = 2'd3;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_USED  = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
        logic access;
        logic finish;
        logic clear_second;
    } sac_cmd_t;

    typedef struct packed {
        logic clear_done;
    } sac_status_t;

endpackage

// ----- rtl/sac_ram.sv -----
// Generic RAM with one write port and one read port, with registered read.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/sac_ctrl.sv -----
// Controller state machine sequencing lookup and update of one record.
module sac_ctrl import sac_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  func,
    input  sac_status_t status,
    output logic        busy,
    output sac_cmd_t    cmd
);
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_READ2 = 6'b010000,
        ST_UPD2  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   modify_reg, modify_next;

    always_comb
    begin
        state_next  = state_reg;
        modify_next = modify_reg;
        cmd         = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load         = 1'b1;
                    cmd.clear_second = 1'b1;
                    modify_next      = (func == FUNC_MODIFY);
                    if (func == FUNC_INSTR)
                    begin
                        cmd.finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_UPD;
            ST_UPD:
            begin
                cmd.access = 1'b1;
                if (modify_reg)
                begin
                    state_next = ST_READ2;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ2: state_next = ST_UPD2;
            ST_UPD2:
            begin
                cmd.access = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            modify_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            modify_reg <= modify_next;
        end
    end
endmodule

// ----- rtl/sac_dp.sv -----
// Datapath: set memories, way compare, victim choice, rank update, totals.
module sac_dp import sac_pkg::*; #(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sac_cmd_t             cmd,
    input  logic [1:0]           func,
    input  logic [63:0]          address,
    input  logic [2:0]           set_bits,
    input  logic [5:0]           block_bits,
    input  logic [3:0]           ways_used,
    output sac_status_t          status,
    output logic                 done,
    output logic [1:0]           outcome,
    output logic                 second_hit,
    output logic [31:0]          hit_total,
    output logic [31:0]          miss_total,
    output logic [31:0]          eviction_total
);
    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int SW     = MAX_SET_BITS;
    localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TW     = ADDR_BITS - 1;
    localparam int MW     = MAX_WAYS * (RW + 1);
    localparam int SBW    = $clog2(MAX_SET_BITS + 1);
    localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);
    localparam logic [31:0]   SAT  = 32'hFFFF_FFFF;

    logic [SW-1:0] set_reg;
    logic [TW-1:0] tag_reg;
    logic [WW:0]   ways_reg;
    logic [SW-1:0] clr_reg;

    logic [SBW-1:0] sb;
    logic [5:0]     bb;
    logic [WW:0]    wn;
    logic [ADDR_BITS-1:0] a, sh;

    always_comb
    begin
        sb = (set_bits == 3'd0) ? SBW'(1)
           : ((32'(set_bits) > MAX_SET_BITS) ? SBW'(MAX_SET_BITS) : SBW'(set_bits));
        bb = (block_bits == 6'd0) ? 6'd1 : ((block_bits > 6'd32) ? 6'd32 : block_bits);
        wn = (ways_used == 4'd0) ? (WW+1)'(1)
           : ((32'(ways_used) > MAX_WAYS) ? (WW+1)'(MAX_WAYS) : (WW+1)'(ways_used));
        a  = address[ADDR_BITS-1:0];
        sh = a >> bb;
    end

    logic [TW-1:0]       tag_rd [MAX_WAYS];
    logic [MAX_WAYS-1:0] tag_we;
    logic [MW-1:0]       meta_rd, meta_wr, meta_wdata;
    logic [MAX_WAYS-1:0] v_rd;
    logic [RW-1:0]       r_rd [MAX_WAYS];
    logic [SW-1:0]       meta_waddr, ram_raddr;

    logic [SW-1:0] set_idx;
    logic [TW-1:0] tag_calc;
    always_comb
    begin
        set_idx  = SW'(sh & ((ADDR_BITS'(1) << sb) - ADDR_BITS'(1)));
        tag_calc = TW'(sh >> sb);
    end

    always_comb
    begin
        v_rd = meta_rd[MAX_WAYS-1:0];
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            r_rd[i] = meta_rd[MAX_WAYS + i*RW +: RW];
        end
    end

    logic hit, full;
    logic [WW-1:0] hw, fw, vw, tw;
    logic [RW-1:0] best, old;
    logic [1:0]    res;
    always_comb
    begin
        hit  = 1'b0; hw = '0;
        full = 1'b1; fw = '0;
        vw   = '0;   best = r_rd[0];
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if ((WW+1)'(i) < ways_reg)
            begin
                if (v_rd[i] && tag_rd[i] == tag_reg)
                begin
                    hit = 1'b1; hw = WW'(i);
                end
                if (!v_rd[i])
                begin
                    full = 1'b0; fw = WW'(i);
                end
            end
        end
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if ((WW+1)'(i) < ways_reg && r_rd[i] > best)
            begin
                best = r_rd[i]; vw = WW'(i);
            end
        end
        if (hit)       begin tw = hw; old = r_rd[hw]; res = OUT_HIT;   end
        else if (!full) begin tw = fw; old = RMAX;     res = OUT_MISS;  end
        else           begin tw = vw; old = best;     res = OUT_EVICT; end
    end

    logic fresh;
    assign fresh = !hit && !full;

    always_comb
    begin
        meta_wr = meta_rd;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WW'(w) == tw)
            begin
                meta_wr[w] = 1'b1;
                meta_wr[MAX_WAYS + w*RW +: RW] = '0;
            end
            else if ((WW+1)'(w) < ways_reg && v_rd[w]
                     && (fresh ? 1'b1 : (r_rd[w] < old))
                     && r_rd[w] < RMAX)
            begin
                meta_wr[MAX_WAYS + w*RW +: RW] = r_rd[w] + RW'(1);
            end
        end
    end

    assign meta_wdata = cmd.clear ? '0 : meta_wr;
    assign meta_waddr = cmd.clear ? clr_reg : set_reg;
    assign ram_raddr  = cmd.load ? set_idx : set_reg;
    assign status.clear_done = (clr_reg == SW'(SETS - 1));

    sac_ram #(.WIDTH(MW), .DEPTH(SETS)) u_meta (
        .clk   (clk),
        .we    (cmd.clear || cmd.access),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (ram_raddr),
        .rdata (meta_rd)
    );

    genvar g;
    generate
        for (g = 0; g < MAX_WAYS; g++)
        begin : g_way
            assign tag_we[g] = cmd.access && !hit && (tw == WW'(g));
            sac_ram #(.WIDTH(TW), .DEPTH(SETS)) u_tag (
                .clk   (clk),
                .we    (tag_we[g]),
                .waddr (set_reg),
                .wdata (tag_reg),
                .raddr (ram_raddr),
                .rdata (tag_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            done           <= 1'b0;
            outcome        <= OUT_NONE;
            second_hit     <= 1'b0;
            hit_total      <= '0;
            miss_total     <= '0;
            eviction_total <= '0;
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + SW'(1);
            end
            if (cmd.clear_second)
            begin
                second_hit <= 1'b0;
                outcome    <= OUT_NONE;
            end
            if (cmd.access)
            begin
                if (cmd.clear_second == 1'b0 && func == FUNC_MODIFY && outcome != OUT_NONE)
                begin
                    second_hit <= hit;
                end
                else
                begin
                    outcome <= res;
                end
                if (hit)
                begin
                    if (hit_total != SAT) hit_total <= hit_total + 32'd1;
                end
                else
                begin
                    if (miss_total != SAT) miss_total <= miss_total + 32'd1;
                    if (full && eviction_total != SAT)
                    begin
                        eviction_total <= eviction_total + 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg  <= set_idx;
            tag_reg  <= tag_calc;
            ways_reg <= wn;
        end
    end
endmodule

// ----- rtl/set_assoc_lru_cache_sim.sv -----
// Top level of the set-associative LRU cache simulator.
// A record is taken when start is high and busy is low. After reset, busy stays
// high while the line state of 2^MAX_SET_BITS sets (64 by default) is cleared.
// An instruction record completes from idle; a load or store passes through
// the read and update states, a modify through both twice; each record gives one
// result, shown for one cycle with done high. The receiver cannot stall: read the
// result in the cycle that done is high. Ranks are written in the update state.
module set_assoc_lru_cache_sim import sac_pkg::*; #(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [63:0] address,
    output logic        done,
    output logic [1:0]  outcome,
    output logic        second_hit,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] eviction_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    sac_cmd_t    cmd;
    sac_status_t status;
    logic [1:0]  func_reg;
    logic [2:0]  set_bits_reg;
    logic [5:0]  block_bits_reg;
    logic [3:0]  ways_used_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd1;
            block_bits_reg <= 6'd1;
            ways_used_reg  <= 4'd1;
            func_reg       <= FUNC_INSTR;
        end
        else
        begin
            if (cmd.load) func_reg <= func;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                    CFG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                    default:        ;
                endcase
            end
        end
    end

    sac_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    sac_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .func           (func_reg),
        .address        (address),
        .set_bits       (set_bits_reg),
        .block_bits     (block_bits_reg),
        .ways_used      (ways_used_reg),
        .status         (status),
        .done           (done),
        .outcome        (outcome),
        .second_hit     (second_hit),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );
endmodule

// ----- tb/set_assoc_lru_cache_sim_chk.sv -----
// Checker for the cache simulator: watches requests, predicts results, compares them.
module set_assoc_lru_cache_sim_chk import sac_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [63:0] address,
    input  logic        done,
    input  logic [1:0]  outcome,
    input  logic        second_hit,
    input  logic [31:0] hit_total,
    input  logic [31:0] miss_total,
    input  logic [31:0] eviction_total,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output int          fails,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = 1 << MAX_SET_BITS_DEF;
    localparam int NWAYS = MAX_WAYS_DEF;

    typedef struct {
        logic [1:0]  outcome;
        logic        second_hit;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } cache_result_t;

    cache_result_t result_q[$];

    logic [2:0]  set_bits_r;
    logic [5:0]  block_bits_r;
    logic [3:0]  ways_r;
    logic        valid_m[NSETS][NWAYS];
    logic [63:0] tag_m[NSETS][NWAYS];
    int          rank_m[NSETS][NWAYS];
    logic [31:0] hits_c, misses_c, evicts_c;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function automatic void make_mru(int s, int w, int ways, int old);
        for (int i = 0; i < ways; i++)
            if (i != w && valid_m[s][i] && rank_m[s][i] < old && rank_m[s][i] < NWAYS - 1)
                rank_m[s][i]++;
        rank_m[s][w] = 0;
    endfunction

    function automatic logic [1:0] lookup_line(logic [63:0] a);
        int sb, bb, ways, s, victim, best;
        logic [63:0] tg;
        sb   = clamp(set_bits_r, 1, MAX_SET_BITS_DEF);
        bb   = clamp(block_bits_r, 1, 32);
        ways = clamp(ways_r, 1, NWAYS);
        s    = int'((a >> bb) & ((64'd1 << sb) - 64'd1));
        tg   = a >> (bb + sb);
        for (int i = 0; i < ways; i++)
            if (valid_m[s][i] && tag_m[s][i] == tg)
            begin
                make_mru(s, i, ways, rank_m[s][i]);
                hits_c = sat_inc(hits_c);
                return OUT_HIT;
            end
        misses_c = sat_inc(misses_c);
        for (int i = 0; i < ways; i++)
            if (!valid_m[s][i])
            begin
                make_mru(s, i, ways, NWAYS);
                valid_m[s][i] = 1'b1;
                tag_m[s][i] = tg;
                return OUT_MISS;
            end
        victim = 0;
        best = rank_m[s][0];
        for (int i = 1; i < ways; i++)
            if (rank_m[s][i] > best)
            begin
                best = rank_m[s][i];
                victim = i;
            end
        make_mru(s, victim, ways, best);
        tag_m[s][victim] = tg;
        evicts_c = sat_inc(evicts_c);
        return OUT_EVICT;
    endfunction

    function automatic cache_result_t predict_record(logic [1:0] f, logic [63:0] a);
        cache_result_t r;
        r.outcome = OUT_NONE;
        r.second_hit = 1'b0;
        if (f != FUNC_INSTR)
        begin
            r.outcome = lookup_line(a);
            if (f == FUNC_MODIFY)
                r.second_hit = (lookup_line(a) == OUT_HIT);
        end
        r.hits = hits_c;
        r.misses = misses_c;
        r.evictions = evicts_c;
        return r;
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t exp_r;
        if (!rst_n)
        begin
            set_bits_r = 3'd1;
            block_bits_r = 6'd1;
            ways_r = 4'd1;
            hits_c = '0;
            misses_c = '0;
            evicts_c = '0;
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++)
                begin
                    valid_m[s][w] = 1'b0;
                    tag_m[s][w] = '0;
                    rank_m[s][w] = 0;
                end
            result_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fails++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (outcome !== exp_r.outcome)
                    begin
                        $error("outcome exp %0d got %0d", exp_r.outcome, outcome);
                        fails++;
                    end
                    if (second_hit !== exp_r.second_hit)
                    begin
                        $error("second_hit exp %0d got %0d", exp_r.second_hit, second_hit);
                        fails++;
                    end
                    if (hit_total !== exp_r.hits)
                    begin
                        $error("hit_total exp %0d got %0d", exp_r.hits, hit_total);
                        fails++;
                    end
                    if (miss_total !== exp_r.misses)
                    begin
                        $error("miss_total exp %0d got %0d", exp_r.misses, miss_total);
                        fails++;
                    end
                    if (eviction_total !== exp_r.evictions)
                    begin
                        $error("eviction_total exp %0d got %0d", exp_r.evictions,
                               eviction_total);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                result_q.push_back(predict_record(func, address));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SET_BITS)
                    set_bits_r = cfg_data[2:0];
                else if (cfg_index == CFG_BLOCK_BITS)
                    block_bits_r = cfg_data;
                else if (cfg_index == CFG_WAYS_USED)
                    ways_r = cfg_data[3:0];
            end
        end
    end

    initial fails = 0;
endmodule

// ----- tb/set_assoc_lru_cache_sim_tb.sv -----
// Testbench top for the cache simulator: stimulus, configuration phases and verdict.
module set_assoc_lru_cache_sim_tb import sac_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_STORE = 2'd2;
    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam int IDLE_LIMIT = 2000;

    logic        clk, rst_n, start, busy, done, second_hit;
    logic [1:0]  func, outcome, cfg_index;
    logic [63:0] address;
    logic [31:0] hit_total, miss_total, eviction_total;
    logic        cfg_valid, cfg_ready;
    logic [5:0]  cfg_data;
    int          fails, pending, requests, phases, burst_left, idle_cycles;
    int          cur_sb, cur_bb, cur_ways;

    set_assoc_lru_cache_sim u_top (.*);

    set_assoc_lru_cache_sim_chk u_chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("set_assoc_lru_cache_sim_tb NOT OK");
            $finish;
        end
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        start = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_SET_BITS)
            cur_sb = clamp(val[2:0], 1, MAX_SET_BITS_DEF);
        else if (idx == CFG_BLOCK_BITS)
            cur_bb = clamp(val, 1, 32);
        else if (idx == CFG_WAYS_USED)
            cur_ways = clamp(val[3:0], 1, MAX_WAYS_DEF);
    endtask

    task automatic configure(logic [5:0] sb, logic [5:0] bb, logic [5:0] ways);
        drain();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_BLOCK_BITS, bb);
        write_reg(CFG_WAYS_USED, ways);
        phases++;
    endtask

    task automatic send(logic [1:0] f, logic [63:0] a);
        if (burst_left == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        start = 1'b1;
        func = f;
        address = a;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        requests++;
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic logic [63:0] pick_address();
        logic [63:0] tg, st, off;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        tg  = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                           : 64'($urandom_range(0, cur_ways + 2));
        st  = 64'($urandom_range(0, (1 << cur_sb) - 1) & 3);
        off = {$urandom, $urandom} & ((64'd1 << cur_bb) - 64'd1);
        return (tg << (cur_bb + cur_sb)) | (st << cur_bb) | off;
    endfunction

    function automatic logic [1:0] pick_func();
        int r;
        r = $urandom_range(0, 9);
        return (r == 0) ? FUNC_INSTR : (r < 4) ? FUNC_LOAD : (r < 7) ? FUNC_STORE
                                                            : FUNC_MODIFY;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_INSTR;
        address = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_data = '0;
        requests = 0;
        phases = 0;
        burst_left = 0;
        idle_cycles = 0;
        cur_sb = 1;
        cur_bb = 1;
        cur_ways = 1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(FUNC_INSTR, '1);
        send(FUNC_LOAD, 64'd0);
        send(FUNC_LOAD, 64'd1);
        send(FUNC_STORE, 64'd8);
        send(FUNC_MODIFY, '1);
        send(FUNC_MODIFY, '1);
        send(FUNC_LOAD, 64'h8000_0000_0000_0000);
        send(FUNC_STORE, 64'h5555_5555_5555_5555);
        send(FUNC_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
        send(FUNC_INSTR, 64'hAAAA_AAAA_AAAA_AAAA);
        configure(6'd2, 6'd4, 6'd2);
        send(FUNC_LOAD, 64'h000);
        send(FUNC_LOAD, 64'h100);
        send(FUNC_LOAD, 64'h000);
        send(FUNC_STORE, 64'h200);
        send(FUNC_MODIFY, 64'h100);
        send(FUNC_LOAD, 64'h300);
        drain();
        write_reg(CFG_SPARE, 6'h3F);

        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: configure(6'd1, 6'd1, 6'd1);
                1: configure(6'd6, 6'd32, 6'd8);
                2: configure(6'd3, 6'd6, 6'd4);
                3: configure(6'd0, 6'd0, 6'd0);
                4: configure(6'd7, 6'd63, 6'd15);
                5: configure(6'd1, 6'd3, 6'd8);
                6: configure(6'd2, 6'd33, 6'd9);
                7: configure(6'd6, 6'd1, 6'd2);
                default: configure(6'd2, 6'd5, 6'd3);
            endcase
            for (int k = 0; k < 72; k++)
                send(pick_func(), pick_address());
        end
        start = 1'b0;
        drain();
        $display("%0d requests over %0d register settings, hits %0d misses %0d evictions %0d",
                 requests, phases, hit_total, miss_total, eviction_total);
        if (fails == 0)
            $display("set_assoc_lru_cache_sim_tb OK");
        else
            $display("set_assoc_lru_cache_sim_tb NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_ctrl.sv
rtl/sac_dp.sv
rtl/set_assoc_lru_cache_sim.sv
tb/set_assoc_lru_cache_sim_chk.sv
tb/set_assoc_lru_cache_sim_tb.sv
